// ===== rtl/hsvrgb_pkg.sv =====
// shared types and constants for the hsv to rgb converter
`timescale 1ns / 1ps

package hsvrgb_pkg;

    localparam int unsigned HueW  = 16;
    localparam int unsigned FixW  = 13;
    localparam int unsigned FracW = 12;
    localparam int unsigned TermW = 24;
    localparam int unsigned ChanW = 8;

    localparam logic [HueW-1:0]  HUE_FULL   = 16'd23040;
    localparam logic [FracW-1:0] HUE_SECTOR = 12'd3840;
    localparam logic [FixW-1:0]  FIX_ONE    = 13'd4096;
    // 1.0 in the product format, 4096 * 3840
    localparam logic [TermW-1:0] TERM_ONE   = 24'd15728640;

    typedef enum logic [2:0] {
        SECTOR_0 = 3'd0,
        SECTOR_1 = 3'd1,
        SECTOR_2 = 3'd2,
        SECTOR_3 = 3'd3,
        SECTOR_4 = 3'd4,
        SECTOR_5 = 3'd5
    } sector_t;

    typedef struct packed {
        logic [HueW-1:0] hue;
        logic [FixW-1:0] saturation;
        logic [FixW-1:0] brightness;
    } hsv_word_t;

    typedef struct packed {
        logic [ChanW-1:0] red;
        logic [ChanW-1:0] green;
        logic [ChanW-1:0] blue;
    } rgb_word_t;

endpackage

// ===== rtl/hsv_to_rgb_converter.sv =====
// hsv to rgb converter: three-stage pipeline with valid bits and stall
// an accepted hsv word passes the stage 1, stage 2 and output registers to become its rgb word
// throughput: one word per cycle while rgb_stall is low, set by the three stage registers each
//   taking a word every cycle (one 18x24 multiplier per channel in the last stage)
// reset: rst_n asynchronous active low clears the valid bits only; no state otherwise
`timescale 1ns / 1ps

module hsv_to_rgb_converter
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pix_valid,
    output logic                   pix_stall,
    input  hsvrgb_pkg::hsv_word_t  pix,
    output logic                   rgb_valid,
    input  logic                   rgb_stall,
    output hsvrgb_pkg::rgb_word_t  rgb
);

    localparam int unsigned ProdW = 42;
    localparam int unsigned V17W  = 18;
    // half of the 2^32 output scale, for round half up
    localparam logic [ProdW-1:0] ROUND_HALF = 42'h0_8000_0000;

    // the math reduces to (17 * v * term + 2^31) >> 32, since
    // 255 / (4096 * 4096 * 3840) = 17 / 2^32

    // ---------------- stage enables ----------------
    logic out_en;
    logic s2_en;
    logic s1_en;

    logic s1_valid_reg;
    logic s2_valid_reg;
    logic rgb_valid_reg;

    assign out_en    = !rgb_valid_reg || !rgb_stall;
    assign s2_en     = !s2_valid_reg || out_en;
    assign s1_en     = !s1_valid_reg || s2_en;
    assign pix_stall = !s1_en;

    // ---------------- stage 1: wrap, clamp, sector split ----------------
    logic [hsvrgb_pkg::HueW-1:0]  hue_w;
    logic [hsvrgb_pkg::FixW-1:0]  sat_c;
    logic [hsvrgb_pkg::FixW-1:0]  val_c;
    hsvrgb_pkg::sector_t          sector_next;
    logic [hsvrgb_pkg::HueW-1:0]  base;
    logic [hsvrgb_pkg::HueW-1:0]  frac_wide;
    logic [hsvrgb_pkg::FracW-1:0] frac_next;
    logic [hsvrgb_pkg::FracW-1:0] frac_c_next;

    always_comb
    begin
        hue_w = (pix.hue >= hsvrgb_pkg::HUE_FULL) ? '0 : pix.hue;
        sat_c = (pix.saturation > hsvrgb_pkg::FIX_ONE) ? hsvrgb_pkg::FIX_ONE : pix.saturation;
        val_c = (pix.brightness > hsvrgb_pkg::FIX_ONE) ? hsvrgb_pkg::FIX_ONE : pix.brightness;

        // sector boundaries at multiples of 60 degrees
        priority if (hue_w >= 16'd19200)
        begin
            sector_next = hsvrgb_pkg::SECTOR_5;
            base        = 16'd19200;
        end
        else if (hue_w >= 16'd15360)
        begin
            sector_next = hsvrgb_pkg::SECTOR_4;
            base        = 16'd15360;
        end
        else if (hue_w >= 16'd11520)
        begin
            sector_next = hsvrgb_pkg::SECTOR_3;
            base        = 16'd11520;
        end
        else if (hue_w >= 16'd7680)
        begin
            sector_next = hsvrgb_pkg::SECTOR_2;
            base        = 16'd7680;
        end
        else if (hue_w >= 16'd3840)
        begin
            sector_next = hsvrgb_pkg::SECTOR_1;
            base        = 16'd3840;
        end
        else
        begin
            sector_next = hsvrgb_pkg::SECTOR_0;
            base        = 16'd0;
        end

        frac_wide   = hue_w - base;
        frac_next   = frac_wide[hsvrgb_pkg::FracW-1:0];
        frac_c_next = hsvrgb_pkg::HUE_SECTOR - frac_next;
    end

    hsvrgb_pkg::sector_t          s1_sector_reg;
    logic [hsvrgb_pkg::FracW-1:0] s1_frac_reg;
    logic [hsvrgb_pkg::FracW-1:0] s1_frac_c_reg;
    logic [hsvrgb_pkg::FixW-1:0]  s1_sat_reg;
    logic [hsvrgb_pkg::FixW-1:0]  s1_val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_en)
        begin
            s1_valid_reg <= pix_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en && pix_valid)
        begin
            s1_sector_reg <= sector_next;
            s1_frac_reg   <= frac_next;
            s1_frac_c_reg <= frac_c_next;
            s1_sat_reg    <= sat_c;
            s1_val_reg    <= val_c;
        end
    end

    // ---------------- stage 2: p, q, t terms and channel select ----------------
    logic [hsvrgb_pkg::FixW+hsvrgb_pkg::FracW-1:0] sf;
    logic [hsvrgb_pkg::FixW+hsvrgb_pkg::FracW-1:0] sfc;
    logic [hsvrgb_pkg::FixW-1:0]  one_minus_s;
    logic [hsvrgb_pkg::TermW:0]   term_p_wide;
    logic [hsvrgb_pkg::TermW-1:0] term_p;
    logic [hsvrgb_pkg::TermW-1:0] term_q;
    logic [hsvrgb_pkg::TermW-1:0] term_t;
    logic [hsvrgb_pkg::TermW-1:0] red_term_next;
    logic [hsvrgb_pkg::TermW-1:0] green_term_next;
    logic [hsvrgb_pkg::TermW-1:0] blue_term_next;
    logic [V17W-1:0]              v17_next;

    always_comb
    begin
        sf  = s1_sat_reg * s1_frac_reg;
        sfc = s1_sat_reg * s1_frac_c_reg;

        term_q = hsvrgb_pkg::TERM_ONE - sf[hsvrgb_pkg::TermW-1:0];
        term_t = hsvrgb_pkg::TERM_ONE - sfc[hsvrgb_pkg::TermW-1:0];

        // (1 - s) * 3840 as (x << 12) - (x << 8)
        one_minus_s = hsvrgb_pkg::FIX_ONE - s1_sat_reg;
        term_p_wide = {one_minus_s, 12'd0} - {4'd0, one_minus_s, 8'd0};
        term_p      = term_p_wide[hsvrgb_pkg::TermW-1:0];

        v17_next = {1'b0, s1_val_reg, 4'd0} + {5'd0, s1_val_reg};

        unique case (s1_sector_reg)
            hsvrgb_pkg::SECTOR_0:
            begin
                red_term_next   = hsvrgb_pkg::TERM_ONE;
                green_term_next = term_t;
                blue_term_next  = term_p;
            end
            hsvrgb_pkg::SECTOR_1:
            begin
                red_term_next   = term_q;
                green_term_next = hsvrgb_pkg::TERM_ONE;
                blue_term_next  = term_p;
            end
            hsvrgb_pkg::SECTOR_2:
            begin
                red_term_next   = term_p;
                green_term_next = hsvrgb_pkg::TERM_ONE;
                blue_term_next  = term_t;
            end
            hsvrgb_pkg::SECTOR_3:
            begin
                red_term_next   = term_p;
                green_term_next = term_q;
                blue_term_next  = hsvrgb_pkg::TERM_ONE;
            end
            hsvrgb_pkg::SECTOR_4:
            begin
                red_term_next   = term_t;
                green_term_next = term_p;
                blue_term_next  = hsvrgb_pkg::TERM_ONE;
            end
            default:
            begin
                red_term_next   = hsvrgb_pkg::TERM_ONE;
                green_term_next = term_p;
                blue_term_next  = term_q;
            end
        endcase
    end

    logic [hsvrgb_pkg::TermW-1:0] s2_red_term_reg;
    logic [hsvrgb_pkg::TermW-1:0] s2_green_term_reg;
    logic [hsvrgb_pkg::TermW-1:0] s2_blue_term_reg;
    logic [V17W-1:0]              s2_v17_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_en && s1_valid_reg)
        begin
            s2_red_term_reg   <= red_term_next;
            s2_green_term_reg <= green_term_next;
            s2_blue_term_reg  <= blue_term_next;
            s2_v17_reg        <= v17_next;
        end
    end

    // ---------------- stage 3: scale by 17 * v, round, take bits 39:32 ----------------
    logic [ProdW-1:0] red_sum;
    logic [ProdW-1:0] green_sum;
    logic [ProdW-1:0] blue_sum;

    always_comb
    begin
        red_sum   = (s2_v17_reg * s2_red_term_reg) + ROUND_HALF;
        green_sum = (s2_v17_reg * s2_green_term_reg) + ROUND_HALF;
        blue_sum  = (s2_v17_reg * s2_blue_term_reg) + ROUND_HALF;
    end

    hsvrgb_pkg::rgb_word_t rgb_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rgb_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            rgb_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en && s2_valid_reg)
        begin
            rgb_word_reg.red   <= red_sum[39:32];
            rgb_word_reg.green <= green_sum[39:32];
            rgb_word_reg.blue  <= blue_sum[39:32];
        end
    end

    assign rgb_valid = rgb_valid_reg;
    assign rgb       = rgb_word_reg;

    // ---------------- checks ----------------
    // the sector split must leave f and 3840 - f summing to one sector
    a_frac_split: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> ({1'b0, s1_frac_reg} + {1'b0, s1_frac_c_reg}) ==
                         {1'b0, hsvrgb_pkg::HUE_SECTOR})
        else $error("sector fraction split inconsistent");

    // clamped inputs never exceed 1.0
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (s1_sat_reg <= hsvrgb_pkg::FIX_ONE) &&
                         (s1_val_reg <= hsvrgb_pkg::FIX_ONE))
        else $error("saturation or brightness not clamped");

    // a full pipe with a stalled output must push back on the input
    a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (rgb_valid_reg && rgb_stall && s2_valid_reg && s1_valid_reg) |-> pix_stall)
        else $error("full pipeline accepted a word");

endmodule

// ===== dv/hsv_rgb_checker.sv =====
// checker for the hsv to rgb converter: predicts each rgb word and compares it
`timescale 1ns / 1ps

module hsv_rgb_checker
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pix_valid,
    input  logic                  pix_stall,
    input  hsvrgb_pkg::hsv_word_t pix,
    input  logic                  rgb_valid,
    input  logic                  rgb_stall,
    input  hsvrgb_pkg::rgb_word_t rgb,
    output int unsigned           fail_count,
    output int unsigned           pending
);

    // 4096 * 4096 * 3840, the common denominator of every channel term
    localparam longint unsigned CHAN_DEN = 64'd64424509440;

    hsvrgb_pkg::rgb_word_t rgb_expected[$];
    int unsigned errors = 0;
    int unsigned depth  = 0;

    assign fail_count = errors;
    assign pending    = depth;

    // exact ratio times 255, rounded half up
    function automatic logic [hsvrgb_pkg::ChanW-1:0] chan_of(input longint unsigned num);
        longint unsigned scaled;
        scaled = (num * 64'd255 + CHAN_DEN / 2) / CHAN_DEN;
        return scaled[hsvrgb_pkg::ChanW-1:0];
    endfunction

    function automatic hsvrgb_pkg::rgb_word_t rgb_of_hsv(input hsvrgb_pkg::hsv_word_t w);
        longint unsigned       h, s, v, f, one, nv, np, nq, nt, r, g, b;
        hsvrgb_pkg::sector_t   sect;
        hsvrgb_pkg::rgb_word_t res;
        h   = w.hue;
        s   = w.saturation;
        v   = w.brightness;
        one = longint'(hsvrgb_pkg::TERM_ONE);
        if (h >= longint'(hsvrgb_pkg::HUE_FULL))
            h = 0;
        if (s > longint'(hsvrgb_pkg::FIX_ONE))
            s = longint'(hsvrgb_pkg::FIX_ONE);
        if (v > longint'(hsvrgb_pkg::FIX_ONE))
            v = longint'(hsvrgb_pkg::FIX_ONE);
        sect = hsvrgb_pkg::sector_t'(h / longint'(hsvrgb_pkg::HUE_SECTOR));
        f    = h % longint'(hsvrgb_pkg::HUE_SECTOR);
        nv   = v * one;
        np   = v * (longint'(hsvrgb_pkg::FIX_ONE) - s) * longint'(hsvrgb_pkg::HUE_SECTOR);
        nq   = v * (one - s * f);
        nt   = v * (one - s * (longint'(hsvrgb_pkg::HUE_SECTOR) - f));
        case (sect)
            hsvrgb_pkg::SECTOR_0:
            begin
                r = nv; g = nt; b = np;
            end
            hsvrgb_pkg::SECTOR_1:
            begin
                r = nq; g = nv; b = np;
            end
            hsvrgb_pkg::SECTOR_2:
            begin
                r = np; g = nv; b = nt;
            end
            hsvrgb_pkg::SECTOR_3:
            begin
                r = np; g = nq; b = nv;
            end
            hsvrgb_pkg::SECTOR_4:
            begin
                r = nt; g = np; b = nv;
            end
            default:
            begin
                r = nv; g = np; b = nq;
            end
        endcase
        res.red   = chan_of(r);
        res.green = chan_of(g);
        res.blue  = chan_of(b);
        return res;
    endfunction

    task automatic check_chan(input string name, input logic [hsvrgb_pkg::ChanW-1:0] want,
                              input logic [hsvrgb_pkg::ChanW-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        hsvrgb_pkg::rgb_word_t want;
        if (rst_n)
        begin
            if (pix_valid && !pix_stall)
                rgb_expected.push_back(rgb_of_hsv(pix));
            if (rgb_valid && !rgb_stall)
            begin
                if (rgb_expected.size() == 0)
                begin
                    $display("%0t: unexpected rgb word, expected none, actual %h", $time, rgb);
                    errors++;
                end
                else
                begin
                    want = rgb_expected.pop_front();
                    check_chan("red",   want.red,   rgb.red);
                    check_chan("green", want.green, rgb.green);
                    check_chan("blue",  want.blue,  rgb.blue);
                end
            end
            depth = rgb_expected.size();
        end
    end

endmodule

// ===== dv/tb_hsv_to_rgb_converter.sv =====
// testbench top for the hsv to rgb converter: stimulus, stall pattern and verdict
`timescale 1ns / 1ps

module tb_hsv_to_rgb_converter;

    // idle cycles with no word moving on either side before giving up;
    // the longest legitimate quiet stretch is the long receiver hold
    // plus a sender gap and the pipeline, so this is many times over
    localparam int unsigned IDLE_LIMIT    = 2000;
    localparam int unsigned RANDOM_WORDS  = 650;
    // receiver holds off this long right after these output counts
    localparam int unsigned LONG_HOLD     = 90;
    localparam int unsigned LONG_HOLD_A   = 40;
    localparam int unsigned LONG_HOLD_B   = 400;
    // settle time after the last expected word
    localparam int unsigned DRAIN_CYCLES  = 16;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  pix_valid = 1'b0;
    logic                  rgb_stall = 1'b0;
    hsvrgb_pkg::hsv_word_t pix       = '0;
    logic                  pix_stall;
    logic                  rgb_valid;
    hsvrgb_pkg::rgb_word_t rgb;

    int unsigned fail_count;
    int unsigned pending;

    // words moved on each side and the quiet-cycle count for the watchdog
    int unsigned hsv_sent    = 0;
    int unsigned rgb_taken   = 0;
    int unsigned idle_cycles = 0;

    always #5 clk = ~clk;

    hsv_to_rgb_converter u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .rgb_valid (rgb_valid),
        .rgb_stall (rgb_stall),
        .rgb       (rgb)
    );

    hsv_rgb_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .pix        (pix),
        .rgb_valid  (rgb_valid),
        .rgb_stall  (rgb_stall),
        .rgb        (rgb),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // handshake counters, sampled at the rising edge like the checker
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pix_valid && !pix_stall)
                hsv_sent++;
            if (rgb_valid && !rgb_stall)
                rgb_taken++;
            if ((pix_valid && !pix_stall) || (rgb_valid && !rgb_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // watchdog: a dropped word or a hung handshake ends up here
    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("tb_hsv_to_rgb_converter: FAIL");
        $finish;
    end

    // receiver: after each taken word draw a random stall length;
    // some stretches run with no stall at all, and twice a long hold
    // lets the pipeline fill so the converter has to stall its input
    initial
    begin
        int unsigned hold;
        int unsigned seen;
        hold = 0;
        seen = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rgb_taken != seen)
            begin
                seen = rgb_taken;
                if (seen == LONG_HOLD_A || seen == LONG_HOLD_B)
                    hold = LONG_HOLD;
                else if (((seen >> 6) % 4) == 1)
                    hold = 0;
                else
                    hold = $urandom_range(0, 14);
            end
            if (hold != 0)
            begin
                rgb_stall <= 1'b1;
                hold--;
            end
            else
                rgb_stall <= 1'b0;
        end
    end

    // one hsv word: optional gap with valid low, then offer until taken;
    // returns at the falling edge after the word was accepted
    task automatic send_hsv(input logic [hsvrgb_pkg::HueW-1:0] h,
                            input logic [hsvrgb_pkg::FixW-1:0] s,
                            input logic [hsvrgb_pkg::FixW-1:0] v);
        int unsigned gap;
        // back to back around the long receiver holds and in burst stretches
        if ((hsv_sent >= 30 && hsv_sent < 130) || (hsv_sent >= 390 && hsv_sent < 490)
            || ((hsv_sent >> 5) % 4) == 2)
            gap = 0;
        else
            gap = $urandom_range(0, 14);
        if (gap != 0)
        begin
            pix_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix.hue        <= h;
        pix.saturation <= s;
        pix.brightness <= v;
        pix_valid      <= 1'b1;
        do
            @(posedge clk);
        while (!(pix_valid && !pix_stall));
        @(negedge clk);
    endtask

    initial
    begin
        int unsigned                   kind;
        logic [hsvrgb_pkg::HueW-1:0]   h;
        logic [hsvrgb_pkg::FixW-1:0]   s;
        logic [hsvrgb_pkg::FixW-1:0]   v;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // primaries and secondaries, one per sector start
        send_hsv(16'd0,     13'd4096, 13'd4096);
        send_hsv(16'd3840,  13'd4096, 13'd4096);
        send_hsv(16'd7680,  13'd4096, 13'd4096);
        send_hsv(16'd11520, 13'd4096, 13'd4096);
        send_hsv(16'd15360, 13'd4096, 13'd4096);
        send_hsv(16'd19200, 13'd4096, 13'd4096);
        // last hue of a sector, mid sector, last hue of the circle
        send_hsv(16'd3839,  13'd4096, 13'd4096);
        send_hsv(16'd1920,  13'd2048, 13'd4096);
        send_hsv(16'd23039, 13'd4096, 13'd4096);
        // hue at and past a full turn wraps to zero
        send_hsv(16'd23040, 13'd3000, 13'd3500);
        send_hsv(16'd65535, 13'd3000, 13'd3500);
        send_hsv(16'd40000, 13'd4096, 13'd4096);
        // gray, black, all zero
        send_hsv(16'd9000,  13'd0,    13'd4096);
        send_hsv(16'd9000,  13'd4096, 13'd0);
        send_hsv(16'd0,     13'd0,    13'd0);
        // saturation and brightness above one clamp to one
        send_hsv(16'd13000, 13'd4097, 13'd4097);
        send_hsv(16'd13000, 13'd8191, 13'd8191);
        send_hsv(16'd65535, 13'd8191, 13'd8191);
        send_hsv(16'd21000, 13'd8191, 13'd2048);
        // smallest nonzero terms and a few rounding points
        send_hsv(16'd1,     13'd1,    13'd1);
        send_hsv(16'd17279, 13'd2048, 13'd2048);
        send_hsv(16'd5760,  13'd4095, 13'd8);
        send_hsv(16'd11521, 13'd1,    13'd4095);

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            kind = $urandom_range(0, 9);
            h    = 16'($urandom_range(0, 23039));
            s    = 13'($urandom_range(0, 4096));
            v    = 13'($urandom_range(0, 4096));
            case (kind)
                // any bit pattern
                0:
                begin
                    h = 16'($urandom_range(0, 65535));
                    s = 13'($urandom_range(0, 8191));
                    v = 13'($urandom_range(0, 8191));
                end
                // out of range hue
                1: h = 16'($urandom_range(23040, 65535));
                // sector edges
                2: h = 16'(3840 * $urandom_range(0, 5) + 3839 * $urandom_range(0, 1));
                // around and above one
                3:
                begin
                    s = 13'($urandom_range(4090, 8191));
                    v = 13'($urandom_range(4090, 8191));
                end
                // full or no saturation
                4: s = ($urandom_range(0, 1) != 0) ? hsvrgb_pkg::FIX_ONE : '0;
                default: ;
            endcase
            send_hsv(h, s, v);
        end
        pix_valid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb_hsv_to_rgb_converter: PASS");
        else
            $display("tb_hsv_to_rgb_converter: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/hsvrgb_pkg.sv
rtl/hsv_to_rgb_converter.sv
dv/hsv_rgb_checker.sv
dv/tb_hsv_to_rgb_converter.sv
